@@ rtl/rsc_pkg.sv @@
// Shared types, codes and digit helpers for the radix string converter.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int BASE_BITS      = 5;
    localparam int DIGIT_BITS     = 4;
    localparam int BUF_DEPTH      = 32;
    localparam int BUF_IDX_BITS   = 5;
    localparam int BUF_CNT_BITS   = 6;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUT_BASE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_BASE = 2'd1;

    localparam logic [BASE_BITS-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_BITS-1:0] BASE_MAX   = 5'd16;
    localparam logic [BASE_BITS-1:0] BASE_RESET = 5'd10;
    localparam logic [BASE_BITS-1:0] DIGIT_NONE = 5'd16;

    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;
    localparam logic [7:0] ASCII_UPPERA = 8'h41;
    localparam logic [7:0] ASCII_UPPERF = 8'h46;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [BASE_BITS-1:0] clamp_base(input logic [BASE_BITS-1:0] b);
        logic [BASE_BITS-1:0] r;
        r = b;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end
        return r;
    endfunction

    // Digit value of a character, or DIGIT_NONE when it is not a digit.
    function automatic logic [BASE_BITS-1:0] decode_char(input logic [7:0] c);
        logic [7:0] t;
        logic [BASE_BITS-1:0] r;
        t = 8'd0;
        r = DIGIT_NONE;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            t = c - ASCII_ZERO;
            r = t[BASE_BITS-1:0];
        end else if (c >= ASCII_UPPERA && c <= ASCII_UPPERF) begin
            t = c - ASCII_UPPERA + 8'd10;
            r = t[BASE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [6:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [7:0] t;
        if (d < 4'd10) begin
            t = ASCII_ZERO + {4'd0, d};
        end else begin
            t = ASCII_UPPERA + {4'd0, d} - 8'd10;
        end
        return t[6:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/radix_string_converter.sv @@
// Top level of the radix string converter: digit accumulation, conversion and emission.
//
//   Channel  Direction  Beat contents
//   s_       in         tdata[7:0] digit_char, tlast final_char
//   m_       out        tdata[6:0] out_char, tlast out_final, tuser overflowed/bad_digit
//   cfg_     in         cfg_index register number, cfg_data base value
//
// A character that is not marked last is accumulated into the value while the block stays ready.
// The last character starts the conversion: the bit-serial divider produces each output digit,
// then each digit is read from the buffer (ST_RD) and held on m_ (ST_OUT) until m_tready takes it.
// s_tready is low from the last character until the last digit beat is taken.
// Reset is synchronous on aresetn and sets both bases to ten.
`timescale 1ns / 1ps
`default_nettype none

module radix_string_converter #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [7:0]                           s_tdata,   // [7:0] digit_char
    input  wire logic                                 s_tlast,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [7:0]                           m_tdata,   // [6:0] out_char, [7] zero
    output logic                                      m_tlast,
    output logic      [1:0]                           m_tuser,   // [0] overflowed, [1] bad_digit
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rsc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [rsc_pkg::BASE_BITS-1:0]        cfg_data
);
    import rsc_pkg::*;

    localparam int PW = VALUE_BITS + BASE_BITS;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_START,
        ST_DIV,
        ST_RD,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [BASE_BITS-1:0]    ibase_reg, ibase_next;
    logic [BASE_BITS-1:0]    obase_reg, obase_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    ovf_reg, ovf_next;
    logic                    bad_reg, bad_next;
    logic [BUF_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [BUF_IDX_BITS-1:0] idx_reg, idx_next;
    logic [DIGIT_BITS-1:0]   digit_reg;
    logic [DIGIT_BITS-1:0]   digit_mem [BUF_DEPTH];

    logic [BASE_BITS-1:0]    ib;
    logic [BASE_BITS-1:0]    ob;
    logic [BASE_BITS-1:0]    dval;
    logic [PW-1:0]           prod;
    logic                    div_start;
    logic                    wr_en;
    logic                    s_fire;
    logic                    m_fire;
    div_status_t             div_status;
    logic [VALUE_BITS-1:0]   div_quot;
    logic [DIGIT_BITS-1:0]   div_rem;

    rsc_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (ob),
        .status   (div_status),
        .quotient (div_quot),
        .remainder(div_rem)
    );

    assign ib     = clamp_base(ibase_reg);
    assign ob     = clamp_base(obase_reg);
    assign dval   = decode_char(s_tdata);
    assign prod   = PW'(acc_reg) * PW'(ib) + PW'(dval);
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    assign s_tready  = (state_reg == ST_ACC);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {1'b0, digit_to_ascii(digit_reg)};
    assign m_tlast   = (idx_reg == '0);
    assign m_tuser   = {bad_reg, ovf_reg};
    assign div_start = (state_reg == ST_START);
    assign wr_en     = (state_reg == ST_DIV) && div_status.done && (cnt_reg < BUF_CNT_BITS'(BUF_DEPTH));

    always_comb begin
        state_next = state_reg;
        ibase_next = ibase_reg;
        obase_next = obase_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        bad_next   = bad_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_INPUT_BASE:  ibase_next = cfg_data;
                CFG_OUTPUT_BASE: obase_next = cfg_data;
                default: ;
            endcase
        end
        case (state_reg)
            ST_ACC: begin
                if (s_fire) begin
                    if (dval >= ib) begin
                        bad_next = 1'b1;
                    end else begin
                        acc_next = prod[VALUE_BITS-1:0];
                        if (|prod[PW-1:VALUE_BITS]) begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_status.done) begin
                    acc_next = div_quot;
                    if (wr_en) begin
                        cnt_next = cnt_reg + 1'b1;
                        idx_next = cnt_reg[BUF_IDX_BITS-1:0];
                    end else begin
                        ovf_next = 1'b1;
                        idx_next = BUF_IDX_BITS'(BUF_DEPTH - 1);
                    end
                    state_next = (div_quot == '0) ? ST_RD : ST_START;
                end
            end
            ST_RD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_fire) begin
                    if (idx_reg == '0) begin
                        ovf_next   = 1'b0;
                        bad_next   = 1'b0;
                        cnt_next   = '0;
                        acc_next   = '0;
                        state_next = ST_ACC;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (!aresetn) begin
            state_reg <= ST_ACC;
            ibase_reg <= BASE_RESET;
            obase_reg <= BASE_RESET;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ibase_reg <= ibase_next;
            obase_reg <= obase_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            bad_reg   <= bad_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_mem[cnt_reg[BUF_IDX_BITS-1:0]] <= div_rem;
        end
        if (state_reg == ST_RD) begin
            digit_reg <= digit_mem[idx_reg];
        end
    end

endmodule

`default_nettype wire

@@ rtl/rsc_divider.sv @@
// Bit-serial restoring divider of a wide value by a small radix.
`timescale 1ns / 1ps
`default_nettype none

module rsc_divider #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [VALUE_BITS-1:0]           dividend,
    input  wire logic [rsc_pkg::BASE_BITS-1:0]   divisor,
    output rsc_pkg::div_status_t                 status,
    output logic      [VALUE_BITS-1:0]           quotient,
    output logic      [rsc_pkg::DIGIT_BITS-1:0]  remainder
);
    import rsc_pkg::*;

    localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic [VALUE_BITS-1:0] work_reg, work_next;
    logic [DIGIT_BITS-1:0] rem_reg, rem_next;
    logic [BASE_BITS-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [BASE_BITS-1:0]  trial;
    logic [BASE_BITS-1:0]  diff;
    logic                  qbit;

    always_comb begin
        trial     = {rem_reg, work_reg[VALUE_BITS-1]};
        qbit      = (trial >= dsr_reg);
        diff      = trial - dsr_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(VALUE_BITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            work_next = {work_reg[VALUE_BITS-2:0], qbit};
            rem_next  = qbit ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = work_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire
